// ----- rtl/xns_pkg.sv -----
// Shared types, widths and codes for the XOR-nearest peer shortlist.
// Depends on nothing; every other file of the block imports it.
package xns_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int ID_W = 160;

	localparam logic [1:0] OP_INSERT   = 2'd0;
	localparam logic [1:0] OP_SELECT   = 2'd1;
	localparam logic [1:0] OP_COMPLETE = 2'd2;
	localparam logic [1:0] OP_CLEAR    = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_DROP  = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;
	localparam logic [1:0] ST_LIMIT = 2'd3;

	localparam logic [2:0] CFG_TARGET_HIGH = 3'd0;
	localparam logic [2:0] CFG_TARGET_MID  = 3'd1;
	localparam logic [2:0] CFG_TARGET_LOW  = 3'd2;
	localparam logic [2:0] CFG_MAX_FLIGHT  = 3'd3;
	localparam logic [2:0] CFG_QUERY_LIMIT = 3'd4;

	// Bit positions inside a flag word.
	localparam int F_KNOWN   = 0;
	localparam int F_QUERIED = 1;
	localparam int F_PENDING = 2;

	typedef struct packed {
		logic [1:0]  operation;
		logic        id_present;
		logic [31:0] id_high;
		logic [63:0] id_mid;
		logic [63:0] id_low;
		logic [31:0] peer_address;
		logic [15:0] peer_port;
		logic [4:0]  entry_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  chosen_index;
		logic [31:0] chosen_address;
		logic [15:0] chosen_port;
		logic [5:0]  entries_used;
	} out_item_t;

	typedef struct packed {
		logic             we_id;
		logic             we_ep;
		logic [IDX_W-1:0] addr;
		logic [ID_W-1:0]  id;
		logic [31:0]      ip;
		logic [15:0]      port;
	} mem_wr_t;

endpackage

// ----- rtl/xns_mem.sv -----
// Peer id and endpoint storage: one write port, one registered read port.
// Depends on xns_pkg.
module xns_mem (
	input  logic                      clk,
	input  xns_pkg::mem_wr_t          wr,
	input  logic                      rd_en,
	input  logic [xns_pkg::IDX_W-1:0] rd_addr,
	output logic [xns_pkg::ID_W-1:0]  rd_id,
	output logic [31:0]               rd_ip,
	output logic [15:0]               rd_port
);
	import xns_pkg::*;

	logic [ID_W-1:0] id_mem [TABLE_ENTRIES];
	logic [31:0]     ip_mem [TABLE_ENTRIES];
	logic [15:0]     port_mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.we_id) begin
			id_mem[wr.addr] <= wr.id;
		end
		if (wr.we_ep) begin
			ip_mem[wr.addr] <= wr.ip;
			port_mem[wr.addr] <= wr.port;
		end
		if (rd_en) begin
			rd_id <= id_mem[rd_addr];
			rd_ip <= ip_mem[rd_addr];
			rd_port <= port_mem[rd_addr];
		end
	end

endmodule

// ----- rtl/xns_cmp.sv -----
// Shared XOR-distance comparator: orders two ids by distance to the target.
// Depends on xns_pkg.
module xns_cmp (
	input  logic [xns_pkg::ID_W-1:0] a,
	input  logic [xns_pkg::ID_W-1:0] b,
	input  logic [xns_pkg::ID_W-1:0] target,
	output logic                     lt,
	output logic                     gt
);
	import xns_pkg::*;

	logic [ID_W-1:0] da, db;

	assign da = a ^ target;
	assign db = b ^ target;
	assign lt = da < db;
	assign gt = da > db;

endmodule

// ----- rtl/xor_nearest_shortlist_top.sv -----
// Top level of the XOR-nearest peer shortlist: sequencer, flags and registers.
// Depends on xns_pkg, xns_mem and xns_cmp.
//
//   channel   direction  handshake            payload
//   in        into       in_valid / in_stall  in_item  (xns_pkg::in_item_t)
//   out       out of     out_valid/ out_stall out_item (xns_pkg::out_item_t)
//   cfg       into       cfg_write            cfg_index, cfg_data
//
// Insert and select scan the used entries at one memory read and one
// 160-bit distance compare per cycle. An insert with an id into a full
// table scans all entries a second time for a victim and then decides in
// S_VDEC; one with no id is dropped. Complete reads the entry and then
// decides in S_CDEC. Reset clears flags, counts and target and loads the
// default limits at once, with no clearing pass. A stalled result waits in
// the output register while the next item is already accepted.
module xor_nearest_shortlist_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  xns_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output xns_pkg::out_item_t out_item,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import xns_pkg::*;

	// Address blocks that an insert refuses.
	localparam logic [15:0] NET_LINK_LOCAL = 16'ha9fe;
	localparam logic [11:0] NET_PRIV_172   = 12'hac1;
	localparam logic [15:0] NET_PRIV_192   = 16'hc0a8;
	localparam logic [9:0]  NET_SHARED     = 10'h191;
	localparam logic [7:0]  NET_LOOPBACK   = 8'd127;
	localparam logic [7:0]  NET_TEN        = 8'd10;
	localparam logic [3:0]  NET_MCAST      = 4'd14;
	localparam logic [6:0]  QUERY_MAX      = 7'd127;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_VSCAN, S_VDEC, S_CREAD, S_CDEC, S_RESP
	} state_t;

	state_t state_q;

	logic [31:0] tgt_high_q;
	logic [63:0] tgt_mid_q, tgt_low_q;
	logic [5:0]  mif_q;
	logic [6:0]  ql_q;

	logic [2:0]       flags_q [TABLE_ENTRIES];
	logic [CNT_W-1:0] used_q, cnt_q, pend_q;
	logic [6:0]       qi_q;

	in_item_t         item_q;
	logic             pv_q;
	logic [IDX_W-1:0] pidx_q;
	logic             found_q, best_known_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [ID_W-1:0]  best_id_q;
	logic [31:0]      best_ip_q;
	logic [15:0]      best_port_q;

	logic [1:0]       res_status_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [31:0]      res_ip_q;
	logic [15:0]      res_port_q;

	logic      out_valid_q;
	out_item_t out_q;
	mem_wr_t   mem_wr_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [ID_W-1:0]  rd_id;
	logic [31:0]      rd_ip;
	logic [15:0]      rd_port;

	logic [ID_W-1:0]  target, item_id, cmp_a;
	logic             cmp_lt, cmp_gt;
	logic             scan_more, ep_ok, cpl_ok, has_id;
	logic [IDX_W-1:0] eidx;
	logic [2:0]       pflags;

	assign target  = {tgt_high_q, tgt_mid_q, tgt_low_q};
	assign item_id = {item_q.id_high, item_q.id_mid, item_q.id_low};
	assign has_id  = item_q.id_present;
	assign eidx    = IDX_W'(item_q.entry_index);
	assign pflags  = flags_q[pidx_q];

	// Only accepted while idle; a finished result may still sit at the output.
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Endpoint filter applied on accept of an insert.
	always_comb begin
		logic [31:0] ip;
		ip = in_item.peer_address;
		ep_ok = (in_item.peer_port != 16'd0) && (ip[31:24] != 8'd0) &&
			(ip[31:24] != NET_TEN) && (ip[31:24] != NET_LOOPBACK) &&
			(ip[31:28] < NET_MCAST) && (ip[31:16] != NET_LINK_LOCAL) &&
			(ip[31:20] != NET_PRIV_172) && (ip[31:16] != NET_PRIV_192) &&
			(ip[31:22] != NET_SHARED);
	end

	// A complete needs an entry in use that is still waiting for a reply.
	assign cpl_ok = (CNT_W'(in_item.entry_index) < used_q) &&
		flags_q[IDX_W'(in_item.entry_index)][F_PENDING];

	always_comb begin
		scan_more = 1'b0;
		rd_en = 1'b0;
		rd_addr = cnt_q[IDX_W-1:0];
		unique case (state_q)
			S_SCAN: begin
				scan_more = cnt_q < used_q;
				rd_en = scan_more;
			end
			S_VSCAN: begin
				scan_more = cnt_q < CNT_W'(TABLE_ENTRIES);
				rd_en = scan_more;
			end
			S_CREAD: begin
				rd_en = 1'b1;
				rd_addr = eidx;
			end
			default: begin
			end
		endcase
	end

	// The victim decision weighs the new id; scans weigh the entry just read.
	assign cmp_a = (state_q == S_VDEC) ? item_id : rd_id;

	xns_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_id   (rd_id),
		.rd_ip   (rd_ip),
		.rd_port (rd_port)
	);

	xns_cmp u_cmp (
		.a      (cmp_a),
		.b      (best_id_q),
		.target (target),
		.lt     (cmp_lt),
		.gt     (cmp_gt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_high_q <= '0;
			tgt_mid_q <= '0;
			tgt_low_q <= '0;
			mif_q <= 6'd4;
			ql_q <= 7'd64;
			flags_q <= '{default: '0};
			used_q <= '0;
			qi_q <= '0;
			pv_q <= 1'b0;
			out_valid_q <= 1'b0;
			mem_wr_q.we_id <= 1'b0;
			mem_wr_q.we_ep <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_TARGET_HIGH: tgt_high_q <= cfg_data[31:0];
					CFG_TARGET_MID:  tgt_mid_q <= cfg_data;
					CFG_TARGET_LOW:  tgt_low_q <= cfg_data;
					CFG_MAX_FLIGHT:  mif_q <= cfg_data[5:0];
					CFG_QUERY_LIMIT: ql_q <= cfg_data[6:0];
					default: begin
					end
				endcase
			end

			// While a result is being loaded the response state drives the flag.
			if (out_valid_q && !out_stall && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_item;
						res_ip_q <= '0;
						res_port_q <= '0;
						cnt_q <= '0;
						pv_q <= 1'b0;
						found_q <= 1'b0;
						pend_q <= '0;
						unique case (in_item.operation)
							OP_INSERT: begin
								res_idx_q <= '0;
								if (!ep_ok) begin
									res_status_q <= ST_DROP;
									state_q <= S_RESP;
								end else begin
									res_status_q <= ST_DONE;
									state_q <= S_SCAN;
								end
							end
							OP_SELECT: begin
								res_status_q <= ST_DONE;
								res_idx_q <= '0;
								state_q <= S_SCAN;
							end
							OP_COMPLETE: begin
								if (!cpl_ok) begin
									res_status_q <= ST_NONE;
									res_idx_q <= '0;
									state_q <= S_RESP;
								end else begin
									res_status_q <= ST_DONE;
									res_idx_q <= IDX_W'(in_item.entry_index);
									state_q <= S_CREAD;
								end
							end
							OP_CLEAR: begin
								res_status_q <= ST_DONE;
								res_idx_q <= '0;
								flags_q <= '{default: '0};
								used_q <= '0;
								qi_q <= '0;
								state_q <= S_RESP;
							end
							default: begin
								res_status_q <= ST_DONE;
								res_idx_q <= '0;
								state_q <= S_RESP;
							end
						endcase
					end
				end

				S_SCAN: begin
					if (scan_more) begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
						pidx_q <= cnt_q[IDX_W-1:0];
					end
					pv_q <= scan_more;
					if (pv_q) begin
						if (item_q.operation == OP_INSERT) begin
							// First entry that matches by endpoint or known id ends the scan.
							if (rd_ip == item_q.peer_address && rd_port == item_q.peer_port) begin
								if (has_id && !pflags[F_KNOWN]) begin
									mem_wr_q.we_id <= 1'b1;
									mem_wr_q.addr <= pidx_q;
									mem_wr_q.id <= item_id;
									flags_q[pidx_q][F_KNOWN] <= 1'b1;
								end
								res_idx_q <= pidx_q;
								state_q <= S_RESP;
							end else if (has_id && pflags[F_KNOWN] && rd_id == item_id) begin
								res_status_q <= ST_DROP;
								state_q <= S_RESP;
							end
						end else begin
							if (pflags[F_PENDING]) begin
								pend_q <= CNT_W'(pend_q + 1'b1);
							end
							if (!pflags[F_QUERIED] && (!found_q || (pflags[F_KNOWN] &&
									(!best_known_q || cmp_lt)))) begin
								found_q <= 1'b1;
								best_known_q <= pflags[F_KNOWN];
								best_idx_q <= pidx_q;
								best_id_q <= rd_id;
								best_ip_q <= rd_ip;
								best_port_q <= rd_port;
							end
						end
					end else if (!scan_more) begin
						if (item_q.operation == OP_INSERT) begin
							if (used_q < CNT_W'(TABLE_ENTRIES)) begin
								mem_wr_q.we_id <= 1'b1;
								mem_wr_q.we_ep <= 1'b1;
								mem_wr_q.addr <= used_q[IDX_W-1:0];
								mem_wr_q.id <= has_id ? item_id : '0;
								mem_wr_q.ip <= item_q.peer_address;
								mem_wr_q.port <= item_q.peer_port;
								flags_q[used_q[IDX_W-1:0]] <= {2'b00, has_id};
								res_idx_q <= used_q[IDX_W-1:0];
								used_q <= CNT_W'(used_q + 1'b1);
								state_q <= S_RESP;
							end else if (!has_id) begin
								res_status_q <= ST_DROP;
								state_q <= S_RESP;
							end else begin
								cnt_q <= '0;
								found_q <= 1'b0;
								state_q <= S_VSCAN;
							end
						end else begin
							if (pend_q >= CNT_W'(mif_q) || qi_q >= ql_q) begin
								res_status_q <= ST_LIMIT;
							end else if (!found_q) begin
								res_status_q <= ST_NONE;
							end else begin
								flags_q[best_idx_q][F_QUERIED] <= 1'b1;
								flags_q[best_idx_q][F_PENDING] <= 1'b1;
								if (qi_q != QUERY_MAX) begin
									qi_q <= qi_q + 7'd1;
								end
								res_idx_q <= best_idx_q;
								res_ip_q <= best_ip_q;
								res_port_q <= best_port_q;
							end
							state_q <= S_RESP;
						end
					end
				end

				S_VSCAN: begin
					if (scan_more) begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
						pidx_q <= cnt_q[IDX_W-1:0];
					end
					pv_q <= scan_more;
					if (pv_q) begin
						// Unknown entries that are not pending always take the slot; else keep the farthest.
						if (!pflags[F_PENDING] && (!found_q || !pflags[F_KNOWN] ||
								(best_known_q && cmp_gt))) begin
							found_q <= 1'b1;
							best_known_q <= pflags[F_KNOWN];
							best_idx_q <= pidx_q;
							best_id_q <= rd_id;
						end
					end else if (!scan_more) begin
						state_q <= S_VDEC;
					end
				end

				S_VDEC: begin
					if (!found_q || (best_known_q && !cmp_lt)) begin
						res_status_q <= ST_DROP;
					end else begin
						mem_wr_q.we_id <= 1'b1;
						mem_wr_q.we_ep <= 1'b1;
						mem_wr_q.addr <= best_idx_q;
						mem_wr_q.id <= item_id;
						mem_wr_q.ip <= item_q.peer_address;
						mem_wr_q.port <= item_q.peer_port;
						flags_q[best_idx_q] <= 3'b001;
						res_idx_q <= best_idx_q;
					end
					state_q <= S_RESP;
				end

				S_CREAD: state_q <= S_CDEC;

				S_CDEC: begin
					if (!has_id) begin
						flags_q[eidx][F_PENDING] <= 1'b0;
					end else if (flags_q[eidx][F_KNOWN] && rd_id != item_id) begin
						res_status_q <= ST_DROP;
					end else begin
						mem_wr_q.we_id <= 1'b1;
						mem_wr_q.addr <= eidx;
						mem_wr_q.id <= item_id;
						flags_q[eidx][F_KNOWN] <= 1'b1;
						flags_q[eidx][F_PENDING] <= 1'b0;
					end
					state_q <= S_RESP;
				end

				S_RESP: begin
					// Any store write was issued by the state before; it lands at this edge.
					mem_wr_q.we_id <= 1'b0;
					mem_wr_q.we_ep <= 1'b0;
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_q.status <= res_status_q;
						out_q.chosen_index <= 5'(res_idx_q);
						out_q.chosen_address <= res_ip_q;
						out_q.chosen_port <= res_port_q;
						out_q.entries_used <= 6'(used_q);
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The fill count never passes the table size.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_ENTRIES))
		else $error("used count beyond table size");

	// A finished item reaches the output register once it is free.
	a_resp_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP) && !(out_valid_q && out_stall) |=> out_valid_q)
		else $error("result not presented");

	// The query count moves by at most one per cycle unless a clear resets it.
	a_qi_step: assert property (@(posedge clk) disable iff (!arst_n)
		(qi_q != $past(qi_q)) |-> (qi_q == $past(qi_q) + 7'd1) || (qi_q == 7'd0))
		else $error("query count jumped");

	// No memory read is issued while a result waits to be sent.
	a_no_read_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP) |-> !rd_en)
		else $error("read during response");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the XOR-nearest peer shortlist (xor_nearest_shortlist_top).
// Depends on xns_pkg and the RTL; a built-in shortlist predictor checks every result item.
module tb_top;
	import xns_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_item;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	xor_nearest_shortlist_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: the shadow shortlist and its registers.
	logic [159:0] sh_target;
	logic [5:0]   sh_max_flight;
	logic [6:0]   sh_query_limit;
	logic [159:0] sh_id [TABLE_ENTRIES];
	logic [31:0]  sh_addr [TABLE_ENTRIES];
	logic [15:0]  sh_port [TABLE_ENTRIES];
	logic [2:0]   sh_flags [TABLE_ENTRIES];
	int           sh_used;
	int           sh_queries;

	out_item_t expected_results[$];
	int        fail_count;
	int        results_seen;
	bit        out_gaps_on;

	// A small pool of endpoints and ids so that merges and duplicates happen often.
	logic [31:0]  pool_addr [8];
	logic [159:0] pool_id [8];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("xor_nearest_shortlist_top: mismatch");
		$finish;
	end

	function automatic logic [159:0] distance(input logic [159:0] id);
		return id ^ sh_target;
	endfunction

	function automatic bit endpoint_usable(input logic [31:0] ip, input logic [15:0] port);
		return port != 0 && ip[31:24] != 8'd0 && ip[31:24] != 8'd10 && ip[31:24] != 8'd127
			&& ip[31:28] < 4'd14 && ip[31:16] != 16'ha9fe && ip[31:20] != 12'hac1
			&& ip[31:16] != 16'hc0a8 && ip[31:22] != 10'h191;
	endfunction

	function automatic void shadow_clear();
		for (int i = 0; i < TABLE_ENTRIES; i++) sh_flags[i] = 3'b000;
		sh_used = 0;
		sh_queries = 0;
	endfunction

	function automatic void shadow_config(input logic [2:0] idx, input logic [63:0] val);
		case (idx)
			CFG_TARGET_HIGH: sh_target[159:128] = val[31:0];
			CFG_TARGET_MID:  sh_target[127:64] = val;
			CFG_TARGET_LOW:  sh_target[63:0] = val;
			CFG_MAX_FLIGHT:  sh_max_flight = val[5:0];
			CFG_QUERY_LIMIT: sh_query_limit = val[6:0];
			default: ;
		endcase
	endfunction

	// Works out the one result item that an accepted item causes and updates the shadow.
	function automatic out_item_t shortlist_step(input in_item_t it);
		out_item_t r;
		logic [159:0] id;
		int slot;
		int pending;
		bit found;
		bit done;
		r = '0;
		id = {it.id_high, it.id_mid, it.id_low};
		done = 0;
		case (it.operation)
			OP_INSERT: begin
				r.status = ST_DONE;
				if (!endpoint_usable(it.peer_address, it.peer_port)) begin
					r.status = ST_DROP;
					done = 1;
				end
				for (int i = 0; i < sh_used && !done; i++) begin
					if (sh_addr[i] == it.peer_address && sh_port[i] == it.peer_port) begin
						if (it.id_present && !sh_flags[i][F_KNOWN]) begin
							sh_id[i] = id;
							sh_flags[i][F_KNOWN] = 1'b1;
						end
						r.chosen_index = 5'(i);
						done = 1;
					end else if (it.id_present && sh_flags[i][F_KNOWN] && sh_id[i] == id) begin
						r.status = ST_DROP;
						done = 1;
					end
				end
				if (!done) begin
					slot = sh_used;
					if (sh_used >= TABLE_ENTRIES) begin
						found = 0;
						slot = 0;
						for (int i = 0; i < TABLE_ENTRIES; i++) begin
							if (sh_flags[i][F_PENDING]) continue;
							if (!found || !sh_flags[i][F_KNOWN] || (sh_flags[slot][F_KNOWN]
									&& distance(sh_id[i]) > distance(sh_id[slot]))) begin
								slot = i;
								found = 1;
							end
						end
						if (!it.id_present || !found || (sh_flags[slot][F_KNOWN]
								&& distance(id) >= distance(sh_id[slot]))) begin
							r.status = ST_DROP;
							done = 1;
						end
					end else begin
						sh_used++;
					end
					if (!done) begin
						sh_addr[slot] = it.peer_address;
						sh_port[slot] = it.peer_port;
						sh_id[slot] = it.id_present ? id : '0;
						sh_flags[slot] = it.id_present ? 3'b001 : 3'b000;
						r.chosen_index = 5'(slot);
					end
				end
			end
			OP_SELECT: begin
				pending = 0;
				for (int i = 0; i < sh_used; i++) pending += sh_flags[i][F_PENDING];
				if (pending >= sh_max_flight || sh_queries >= sh_query_limit) begin
					r.status = ST_LIMIT;
				end else begin
					found = 0;
					slot = 0;
					for (int i = 0; i < sh_used; i++) begin
						if (sh_flags[i][F_QUERIED]) continue;
						if (!found || (sh_flags[i][F_KNOWN] && (!sh_flags[slot][F_KNOWN]
								|| distance(sh_id[i]) < distance(sh_id[slot])))) begin
							slot = i;
							found = 1;
						end
					end
					if (!found) begin
						r.status = ST_NONE;
					end else begin
						sh_flags[slot][F_QUERIED] = 1'b1;
						sh_flags[slot][F_PENDING] = 1'b1;
						if (sh_queries < 127) sh_queries++;
						r.status = ST_DONE;
						r.chosen_index = 5'(slot);
						r.chosen_address = sh_addr[slot];
						r.chosen_port = sh_port[slot];
					end
				end
			end
			OP_COMPLETE: begin
				slot = it.entry_index;
				if (slot >= sh_used || !sh_flags[slot][F_PENDING]) begin
					r.status = ST_NONE;
				end else begin
					r.chosen_index = 5'(slot);
					if (!it.id_present) begin
						sh_flags[slot][F_PENDING] = 1'b0;
					end else if (sh_flags[slot][F_KNOWN] && sh_id[slot] != id) begin
						r.status = ST_DROP;
					end else begin
						sh_id[slot] = id;
						sh_flags[slot][F_KNOWN] = 1'b1;
						sh_flags[slot][F_PENDING] = 1'b0;
					end
				end
			end
			default: shadow_clear();
		endcase
		r.entries_used = 6'(sh_used);
		return r;
	endfunction

	// Gap lengths: mostly none or short, now and then long.
	function automatic int gap_cycles();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Result checker: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result item with no expectation waiting: %p", out_item);
				fail_count++;
			end else begin
				out_item_t e;
				e = expected_results.pop_front();
				if (out_item.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, out_item.status);
					fail_count++;
				end
				if (out_item.chosen_index !== e.chosen_index) begin
					$error("chosen_index expected %0d actual %0d", e.chosen_index,
						out_item.chosen_index);
					fail_count++;
				end
				if (out_item.chosen_address !== e.chosen_address) begin
					$error("chosen_address expected %h actual %h", e.chosen_address,
						out_item.chosen_address);
					fail_count++;
				end
				if (out_item.chosen_port !== e.chosen_port) begin
					$error("chosen_port expected %0d actual %0d", e.chosen_port,
						out_item.chosen_port);
					fail_count++;
				end
				if (out_item.entries_used !== e.entries_used) begin
					$error("entries_used expected %0d actual %0d", e.entries_used,
						out_item.entries_used);
					fail_count++;
				end
			end
		end
	end

	// Receiver side stall: random bursts, switched off for some stretches.
	always @(posedge clk) begin
		if (!arst_n || !out_gaps_on) out_stall <= 1'b0;
		else if ($urandom_range(99) < 30) out_stall <= ($urandom_range(99) < 50);
	end

	// Sends one item: waits out a random gap, then holds it until accepted.
	// Valid stays high after acceptance so that a gapless item follows at once.
	task automatic send_item(input in_item_t it);
		int g;
		g = gap_cycles();
		repeat (g) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		// The item was taken at this edge; the prediction follows acceptance order.
		expected_results.push_back(shortlist_step(it));
	endtask

	// Drops valid and lets the block drain before a register write.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		shadow_config(idx, val);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] public_addr();
		logic [31:0] a;
		do a = $urandom(); while (!endpoint_usable(a, 16'd1));
		return a;
	endfunction

	function automatic in_item_t make_item(input logic [1:0] op);
		in_item_t it;
		it.operation = op;
		it.id_present = $urandom_range(99) < 75;
		it.id_high = $urandom();
		it.id_mid = {$urandom(), $urandom()};
		it.id_low = {$urandom(), $urandom()};
		it.peer_address = $urandom_range(99) < 15 ? $urandom() : public_addr();
		it.peer_port = $urandom_range(99) < 4 ? 16'd0 : 16'($urandom());
		it.entry_index = 5'($urandom_range(31));
		return it;
	endfunction

	// Random mix of operations: mostly inserts, selects and completes.
	function automatic in_item_t random_item();
		in_item_t it;
		int p;
		int k;
		p = $urandom_range(99);
		if (p < 42) begin
			it = make_item(OP_INSERT);
			if ($urandom_range(99) < 25) begin
				k = $urandom_range(7);
				it.peer_address = pool_addr[k];
				it.peer_port = 16'd6881;
				if ($urandom_range(1)) {it.id_high, it.id_mid, it.id_low} = pool_id[k];
			end
		end else if (p < 66) begin
			it = make_item(OP_SELECT);
		end else if (p < 98) begin
			it = make_item(OP_COMPLETE);
			// Aim mostly at pending entries so that completes take effect.
			for (int i = 0; i < sh_used; i++)
				if (sh_flags[i][F_PENDING] && $urandom_range(1)) it.entry_index = 5'(i);
			if ($urandom_range(99) < 20 && sh_flags[it.entry_index][F_KNOWN])
				{it.id_high, it.id_mid, it.id_low} = sh_id[it.entry_index];
		end else begin
			it = make_item(OP_CLEAR);
		end
		return it;
	endfunction

	// Directed: endpoint filters, field extremes and every operation.
	task automatic test_directed();
		in_item_t it;
		logic [31:0] bad [11];
		bad = '{32'h00000001, 32'h0a000001, 32'h7f000001, 32'he0000000, 32'hffffffff,
			32'ha9fe0101, 32'hac100001, 32'hac1fffff, 32'hc0a80001, 32'h64400001, 32'h647fffff};
		foreach (bad[i]) begin
			it = make_item(OP_INSERT);
			it.peer_address = bad[i];
			it.peer_port = 16'hffff;
			send_item(it);
		end
		it = make_item(OP_INSERT);
		it.peer_port = 16'd0;
		send_item(it);
		it = make_item(OP_SELECT);
		send_item(it);
		it = '0;
		it.operation = OP_INSERT;
		it.peer_address = 32'h64800000;
		it.peer_port = 16'hffff;
		send_item(it);
		it.id_present = 1'b1;
		{it.id_high, it.id_mid, it.id_low} = '1;
		it.peer_address = 32'h01000001;
		send_item(it);
		it.peer_address = 32'hdfffffff;
		send_item(it);
		it.peer_address = 32'h64400000;
		it.peer_port = 16'd1;
		send_item(it);
		it = '0;
		it.operation = OP_INSERT;
		it.peer_address = 32'h64800000;
		it.peer_port = 16'hffff;
		it.id_present = 1'b1;
		send_item(it);
		for (int i = 0; i < 3; i++) send_item(make_item(OP_SELECT));
		it = make_item(OP_COMPLETE);
		it.entry_index = 0;
		it.id_present = 1'b1;
		send_item(it);
		it.id_present = 1'b0;
		send_item(it);
		it.entry_index = 5'd31;
		send_item(it);
		send_item(make_item(OP_CLEAR));
	endtask

	// Fills the table and drives replacement and the limits under one setting.
	task automatic test_random_phase(input int n);
		for (int i = 0; i < n; i++) send_item(random_item());
		wait_idle();
	endtask

	task automatic test_full_table();
		in_item_t it;
		for (int i = 0; i < 45; i++) begin
			it = make_item(OP_INSERT);
			it.peer_address = public_addr();
			it.peer_port = 16'd1 + i[15:0];
			it.id_present = (i % 5) != 0;
			send_item(it);
		end
		for (int i = 0; i < 40; i++) send_item(random_item());
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_TARGET_HIGH;
		cfg_data = '0;
		fail_count = 0;
		results_seen = 0;
		out_gaps_on = 1'b1;
		sh_target = '0;
		sh_max_flight = 6'd4;
		sh_query_limit = 7'd64;
		shadow_clear();
		foreach (pool_addr[i]) begin
			pool_addr[i] = public_addr();
			pool_id[i] = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_idle();
		test_full_table();

		// Extreme settings: all-ones target, widest limits.
		write_reg(CFG_TARGET_HIGH, 64'hffffffff_ffffffff);
		write_reg(CFG_TARGET_MID, '1);
		write_reg(CFG_TARGET_LOW, '1);
		write_reg(CFG_MAX_FLIGHT, 64'd32);
		write_reg(CFG_QUERY_LIMIT, 64'd127);
		test_random_phase(150);
		test_full_table();

		// Tightest limits, and a zero limit that always refuses.
		write_reg(CFG_MAX_FLIGHT, 64'd1);
		write_reg(CFG_QUERY_LIMIT, 64'd1);
		test_random_phase(60);
		write_reg(CFG_QUERY_LIMIT, 64'd0);
		write_reg(CFG_MAX_FLIGHT, 64'd0);
		test_random_phase(25);

		// Random target and mid-range limits, then a stretch with no output stalls.
		write_reg(CFG_TARGET_HIGH, {$urandom(), $urandom()});
		write_reg(CFG_TARGET_MID, {$urandom(), $urandom()});
		write_reg(CFG_TARGET_LOW, {$urandom(), $urandom()});
		write_reg(CFG_MAX_FLIGHT, 64'($urandom_range(8, 2)));
		write_reg(CFG_QUERY_LIMIT, 64'($urandom_range(60, 20)));
		test_random_phase(150);
		out_gaps_on = 1'b0;
		test_full_table();
		out_gaps_on = 1'b1;
		write_reg(CFG_MAX_FLIGHT, 64'd6);
		write_reg(CFG_QUERY_LIMIT, 64'd127);
		test_random_phase(80);

		if (fail_count == 0 && expected_results.size() == 0)
			$display("xor_nearest_shortlist_top: match");
		else
			$display("xor_nearest_shortlist_top: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/xns_pkg.sv
rtl/xns_mem.sv
rtl/xns_cmp.sv
rtl/xor_nearest_shortlist_top.sv
dv/tb_top.sv
